### rtl/ps2_mouse_host_tracker_core_defines.svh
// assertion macros shared by the ps2 mouse host tracker rtl
`ifndef PS2_MOUSE_HOST_TRACKER_CORE_DEFINES_SVH
`define PS2_MOUSE_HOST_TRACKER_CORE_DEFINES_SVH

// condition that holds on every clock out of reset
`define PS2MT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PS2MT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PS2MT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ps2mt_pkg.sv
// types and constants of the ps2 mouse host tracker
package ps2mt_pkg;

  localparam int unsigned AXIS_W = 10;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BTN_W  = 3;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [AXIS_W-1:0] WIDTH_RST  = 10'd640;
  localparam logic [AXIS_W-1:0] HEIGHT_RST = 10'd480;
  localparam logic [BYTE_W-1:0] RATE_RST   = 8'h14;

  localparam logic [BYTE_W-1:0] BYTE_SELFTEST = 8'hAA;
  localparam logic [BYTE_W-1:0] BYTE_ACK      = 8'hFA;
  localparam logic [BYTE_W-1:0] CMD_SET_RATE  = 8'hF3;
  localparam logic [BYTE_W-1:0] CMD_ENABLE    = 8'hF4;
  localparam logic [BYTE_W-1:0] CMD_RESET     = 8'hFF;

  typedef enum logic [3:0] {
    PH_SELFTEST = 4'd0,
    PH_ERROR    = 4'd1,
    PH_ID       = 4'd2,
    PH_ACK_CMD  = 4'd3,
    PH_ACK_RATE = 4'd4,
    PH_ACK_EN   = 4'd5,
    PH_PKT1     = 4'd6,
    PH_PKT2     = 4'd7,
    PH_PKT3     = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RATE   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [AXIS_W-1:0] width;
    logic [AXIS_W-1:0] height;
    logic [BYTE_W-1:0] rate;
  } cfg_t;

  typedef struct packed {
    logic              decode;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } pkt_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [BYTE_W-1:0] cmd_byte;
    logic              cmd_flag;
    logic              init_complete;
    phase_t            phase;
  } link_res_t;

endpackage

### rtl/ps2mt_cfg.sv
// apb register file: screen limits and sample rate
module ps2mt_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ps2mt_pkg::ADDR_W-1:0]  paddr,
  input  logic [ps2mt_pkg::DATA_W-1:0]  pwdata,
  output logic [ps2mt_pkg::DATA_W-1:0]  prdata,
  output ps2mt_pkg::cfg_t               cfg
);

  ps2mt_pkg::cfg_t      cfg_r;
  ps2mt_pkg::reg_idx_t  idx;
  logic                 wr_en;

  assign idx   = ps2mt_pkg::reg_idx_t'(paddr[ps2mt_pkg::ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= ps2mt_pkg::WIDTH_RST;
      cfg_r.height <= ps2mt_pkg::HEIGHT_RST;
      cfg_r.rate   <= ps2mt_pkg::RATE_RST;
    end else if (wr_en) begin
      case (idx)
        ps2mt_pkg::REG_WIDTH:  cfg_r.width  <= pwdata[ps2mt_pkg::AXIS_W-1:0];
        ps2mt_pkg::REG_HEIGHT: cfg_r.height <= pwdata[ps2mt_pkg::AXIS_W-1:0];
        ps2mt_pkg::REG_RATE:   cfg_r.rate   <= pwdata[ps2mt_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      ps2mt_pkg::REG_WIDTH:  prdata[ps2mt_pkg::AXIS_W-1:0] = cfg_r.width;
      ps2mt_pkg::REG_HEIGHT: prdata[ps2mt_pkg::AXIS_W-1:0] = cfg_r.height;
      ps2mt_pkg::REG_RATE:   prdata[ps2mt_pkg::BYTE_W-1:0] = cfg_r.rate;
      default:               prdata = '0;
    endcase
  end

endmodule

### rtl/ps2mt_link.sv
// link state machine: bring-up handshake, packet byte capture, watchdog
module ps2mt_link (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          mode,
  input  logic [ps2mt_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [ps2mt_pkg::BYTE_W-1:0]  rate,
  output ps2mt_pkg::link_res_t          res,
  output ps2mt_pkg::pkt_t               pkt
);

  ps2mt_pkg::phase_t phase_r, phase_nxt;
  logic [ps2mt_pkg::BYTE_W-1:0] first_r, first_nxt;
  logic [ps2mt_pkg::BYTE_W-1:0] second_r, second_nxt;
  logic ready_seen_r, ready_seen_nxt;
  logic moved_seen_r, moved_seen_nxt;
  logic is_ack;
  logic wd_expire;

  assign is_ack    = (rx_byte == ps2mt_pkg::BYTE_ACK);
  assign wd_expire = !moved_seen_r && !ready_seen_r;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (mode) begin
      if (wd_expire) phase_nxt = ps2mt_pkg::PH_SELFTEST;
    end else begin
      case (phase_r)
        ps2mt_pkg::PH_SELFTEST,
        ps2mt_pkg::PH_ERROR:    phase_nxt = (rx_byte == ps2mt_pkg::BYTE_SELFTEST) ?
                                            ps2mt_pkg::PH_ID : ps2mt_pkg::PH_ERROR;
        ps2mt_pkg::PH_ID:       phase_nxt = ps2mt_pkg::PH_ACK_CMD;
        ps2mt_pkg::PH_ACK_CMD:  phase_nxt = is_ack ? ps2mt_pkg::PH_ACK_RATE :
                                                     ps2mt_pkg::PH_ERROR;
        ps2mt_pkg::PH_ACK_RATE: phase_nxt = is_ack ? ps2mt_pkg::PH_ACK_EN :
                                                     ps2mt_pkg::PH_ERROR;
        ps2mt_pkg::PH_ACK_EN:   phase_nxt = is_ack ? ps2mt_pkg::PH_PKT1 :
                                                     ps2mt_pkg::PH_ERROR;
        ps2mt_pkg::PH_PKT1:     phase_nxt = ps2mt_pkg::PH_PKT2;
        ps2mt_pkg::PH_PKT2:     phase_nxt = ps2mt_pkg::PH_PKT3;
        ps2mt_pkg::PH_PKT3:     phase_nxt = ps2mt_pkg::PH_PKT1;
        default:                phase_nxt = phase_r;
      endcase
    end
  end

  // outputs and side state
  always_comb begin
    res.cmd_valid     = 1'b0;
    res.cmd_byte      = '0;
    res.cmd_flag      = 1'b0;
    res.init_complete = 1'b0;
    res.phase         = phase_nxt;
    pkt.decode        = 1'b0;
    pkt.b1            = first_r;
    pkt.b2            = second_r;
    pkt.b3            = rx_byte;
    first_nxt         = first_r;
    second_nxt        = second_r;
    ready_seen_nxt    = ready_seen_r;
    moved_seen_nxt    = moved_seen_r;
    if (mode) begin
      // moved activity is consumed first, then the ready mark
      if (moved_seen_r) begin
        moved_seen_nxt = 1'b0;
      end else if (ready_seen_r) begin
        ready_seen_nxt = 1'b0;
      end else begin
        res.cmd_valid = 1'b1;
        res.cmd_byte  = ps2mt_pkg::CMD_RESET;
        res.cmd_flag  = 1'b1;
      end
    end else begin
      case (phase_r)
        ps2mt_pkg::PH_ID: begin
          res.cmd_valid = 1'b1;
          res.cmd_byte  = ps2mt_pkg::CMD_SET_RATE;
          res.cmd_flag  = 1'b1;
        end
        ps2mt_pkg::PH_ACK_CMD: begin
          if (is_ack) begin
            res.cmd_valid = 1'b1;
            res.cmd_byte  = rate;
            res.cmd_flag  = 1'b1;
          end
        end
        ps2mt_pkg::PH_ACK_RATE: begin
          if (is_ack) begin
            res.cmd_valid = 1'b1;
            res.cmd_byte  = ps2mt_pkg::CMD_ENABLE;
          end
        end
        ps2mt_pkg::PH_ACK_EN: begin
          if (is_ack) begin
            ready_seen_nxt    = 1'b1;
            res.init_complete = 1'b1;
          end
        end
        ps2mt_pkg::PH_PKT1: first_nxt = rx_byte;
        ps2mt_pkg::PH_PKT2: second_nxt = rx_byte;
        ps2mt_pkg::PH_PKT3: begin
          pkt.decode     = 1'b1;
          moved_seen_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ps2mt_pkg::PH_SELFTEST;
      first_r      <= '0;
      second_r     <= '0;
      ready_seen_r <= 1'b0;
      moved_seen_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      ready_seen_r <= ready_seen_nxt;
      moved_seen_r <= moved_seen_nxt;
    end
  end

endmodule

### rtl/ps2mt_cursor.sv
// packet decode and saturating cursor / button state
module ps2mt_cursor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  ps2mt_pkg::pkt_t               pkt,
  input  ps2mt_pkg::cfg_t               cfg,
  output logic [ps2mt_pkg::AXIS_W-1:0]  pos_x_nxt,
  output logic [ps2mt_pkg::AXIS_W-1:0]  pos_y_nxt,
  output logic [ps2mt_pkg::BTN_W-1:0]   buttons_nxt
);

  localparam int unsigned SUM_W = ps2mt_pkg::AXIS_W + 2;

  logic [ps2mt_pkg::AXIS_W-1:0] pos_x_r, pos_y_r;
  logic [ps2mt_pkg::BTN_W-1:0]  buttons_r;
  logic signed [ps2mt_pkg::AXIS_W-1:0] dx, dy;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [ps2mt_pkg::AXIS_W-1:0] clamped_x, clamped_y;

  function automatic logic [ps2mt_pkg::AXIS_W-1:0] clamp_axis(
    input logic signed [SUM_W-1:0]    v,
    input logic [ps2mt_pkg::AXIS_W-1:0] lim
  );
    logic [ps2mt_pkg::AXIS_W-1:0] hi;
    hi = (lim == '0) ? '0 : lim - 1'b1;
    if (v < 0) return '0;
    if (v[SUM_W-2:0] > {1'b0, hi}) return hi;
    return v[ps2mt_pkg::AXIS_W-1:0];
  endfunction

  // x: byte2 with sign in bit 4, overflow in bit 6 forces +-255
  always_comb begin
    if (pkt.b1[4]) dx = pkt.b1[6] ? -10'sd255 : $signed({2'b11, pkt.b2});
    else           dx = pkt.b1[6] ?  10'sd255 : $signed({2'b00, pkt.b2});
  end

  // y is inverted: sign in bit 5, overflow in bit 7
  always_comb begin
    if (pkt.b1[5]) dy = pkt.b1[7] ?  10'sd255 : 10'sd256 - $signed({2'b00, pkt.b3});
    else           dy = pkt.b1[7] ? -10'sd255 : 10'sd0 - $signed({2'b00, pkt.b3});
  end

  assign sum_x = $signed({2'b00, pos_x_r}) + SUM_W'(dx);
  assign sum_y = $signed({2'b00, pos_y_r}) + SUM_W'(dy);
  assign clamped_x = clamp_axis(sum_x, cfg.width);
  assign clamped_y = clamp_axis(sum_y, cfg.height);

  assign pos_x_nxt   = pkt.decode ? clamped_x : pos_x_r;
  assign pos_y_nxt   = pkt.decode ? clamped_y : pos_y_r;
  assign buttons_nxt = pkt.decode ? pkt.b1[ps2mt_pkg::BTN_W-1:0] : buttons_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      buttons_r <= '0;
    end else if (step) begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      buttons_r <= buttons_nxt;
    end
  end

endmodule

### rtl/ps2_mouse_host_tracker_core.sv
// ps2 mouse host tracker top: input register, decode, result register
// each item goes from the input register to the result register
// throughput: one item per cycle when out_ready does not stall
// in_ready stays high while the result register is free or being drained
// rst_n (synchronous) clears the link to self-test wait, cursor and buttons
// to zero, and the registers to 640 x 480 with sample rate 20
`include "ps2_mouse_host_tracker_core_defines.svh"

module ps2_mouse_host_tracker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [ps2mt_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_cmd_valid,
  output logic [ps2mt_pkg::BYTE_W-1:0]  out_cmd_byte,
  output logic                          out_cmd_flag,
  output logic [ps2mt_pkg::AXIS_W-1:0]  out_cursor_x,
  output logic [ps2mt_pkg::AXIS_W-1:0]  out_cursor_y,
  output logic [ps2mt_pkg::BTN_W-1:0]   out_button_bits,
  output logic                          out_position_updated,
  output logic                          out_init_complete,
  output logic [3:0]                    out_link_state,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ps2mt_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ps2mt_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ps2mt_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  ps2mt_pkg::cfg_t      cfg;
  ps2mt_pkg::link_res_t link_res;
  ps2mt_pkg::pkt_t      pkt;

  logic                          s1_v_r, s1_v_nxt;
  logic                          s1_mode_r;
  logic [ps2mt_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                          out_v_r, out_v_nxt;
  logic                          step;
  logic                          in_fire;

  logic [ps2mt_pkg::AXIS_W-1:0]  pos_x_nxt, pos_y_nxt;
  logic [ps2mt_pkg::BTN_W-1:0]   buttons_nxt;

  ps2mt_pkg::link_res_t          res_r;
  logic                          upd_r;
  logic [ps2mt_pkg::AXIS_W-1:0]  pos_x_r, pos_y_r;
  logic [ps2mt_pkg::BTN_W-1:0]   buttons_r;

  assign cfg_pready = 1'b1;

  ps2mt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // stage handshake
  assign step     = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || step;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire)   s1_v_nxt = 1'b1;
    else if (step) s1_v_nxt = 1'b0;
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (step)           out_v_nxt = 1'b1;
    else if (out_ready) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_rx_byte;
    end
  end

  ps2mt_link u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .mode    (s1_mode_r),
    .rx_byte (s1_byte_r),
    .rate    (cfg.rate),
    .res     (link_res),
    .pkt     (pkt)
  );

  ps2mt_cursor u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .pkt         (pkt),
    .cfg         (cfg),
    .pos_x_nxt   (pos_x_nxt),
    .pos_y_nxt   (pos_y_nxt),
    .buttons_nxt (buttons_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      res_r     <= link_res;
      upd_r     <= pkt.decode;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      buttons_r <= buttons_nxt;
    end
  end

  assign out_valid            = out_v_r;
  assign out_cmd_valid        = res_r.cmd_valid;
  assign out_cmd_byte         = res_r.cmd_byte;
  assign out_cmd_flag         = res_r.cmd_flag;
  assign out_cursor_x         = pos_x_r;
  assign out_cursor_y         = pos_y_r;
  assign out_button_bits      = buttons_r;
  assign out_position_updated = upd_r;
  assign out_init_complete    = res_r.init_complete;
  assign out_link_state       = res_r.phase;

  `PS2MT_ASSERT_IMPL(a_ready_when_empty, !out_v_r, in_ready,
    "input stalled while result register empty")
  `PS2MT_ASSERT_IMPL(a_idle_cmd_zero, out_v_r && !out_cmd_valid,
    out_cmd_byte == '0 && !out_cmd_flag, "command byte without command valid")
  `PS2MT_ASSERT_IMPL(a_update_phase, out_v_r && out_position_updated,
    out_link_state == ps2mt_pkg::PH_PKT1 && !out_cmd_valid,
    "movement result outside packet start phase")
  `PS2MT_ASSERT_IMPL(a_init_phase, out_v_r && out_init_complete,
    out_link_state == ps2mt_pkg::PH_PKT1 && !out_position_updated,
    "bring-up done without entering packet phase")
  `PS2MT_ASSERT_NEXT(a_step_fills, step, out_v_r,
    "processed item did not reach result register")

endmodule
